/* rtl/core/fdf_pkg.sv */
`default_nettype none

package fdf_pkg;

    localparam int DATA_W  = 24;
    localparam int HIST_N  = 7;
    localparam int CALC_W  = DATA_W + 6;
    localparam int TOT_W   = 27;
    localparam int SPL_W   = 29;
    localparam int SPS_W   = 28;
    localparam int CNT_W   = 5;
    localparam int UP_W    = 4;
    localparam int OFS_W   = 21;
    localparam int ADDR_W  = 5;
    localparam int APB_W   = 32;
    localparam int FIELD_W = 24;
    localparam int IN_W    = 2 * FIELD_W;
    localparam int OUT_W   = 128;

    typedef logic [DATA_W-1:0]        sample_t;
    typedef logic signed [CALC_W-1:0] calc_t;
    typedef logic signed [CNT_W-1:0]  count_t;

    typedef enum logic [2:0] {
        REG_OFS_LONG   = 3'd0,
        REG_OFS_SHORT  = 3'd1,
        REG_UP_LONG    = 3'd2,
        REG_UP_SHORT   = 3'd3,
        REG_DOWN_LONG  = 3'd4,
        REG_DOWN_SHORT = 3'd5
    } reg_idx_t;

    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_CLEAR  = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [UP_W-1:0] up;
        count_t          down;
    } dir_limits_t;

    function automatic calc_t widen(input sample_t h);
        widen = calc_t'({{(CALC_W-DATA_W){1'b0}}, h});
    endfunction

    function automatic calc_t absd(input sample_t a, input sample_t b);
        absd = (a > b) ? (widen(a) - widen(b)) : (widen(b) - widen(a));
    endfunction

endpackage

`default_nettype wire

/* rtl/core/fdf_dir_count.sv */
`default_nettype none

module fdf_dir_count
    import fdf_pkg::*;
(
    input  var calc_t       total,
    input  var calc_t       spread,
    input  var count_t      cnt,
    input  var dir_limits_t limits,
    output count_t          cnt_next
);

    calc_t                  mag;
    logic signed [CNT_W:0]  cnt_ext;
    logic signed [CNT_W:0]  up_ext;
    logic                   responds;
    logic                   rising;

    always_comb begin
        mag      = total[CALC_W-1] ? -total : total;
        cnt_ext  = {cnt[CNT_W-1], cnt};
        up_ext   = {{(CNT_W+1-UP_W){1'b0}}, limits.up};
        responds = mag > spread;
        rising   = !total[CALC_W-1] && (total != '0);
    end

    always_comb begin
        if (!responds) begin
            cnt_next = '0;
        end else if (rising) begin
            cnt_next = (cnt_ext >= up_ext) ? count_t'(up_ext[CNT_W-1:0]) : cnt + count_t'(1);
        end else if (cnt <= limits.down) begin
            cnt_next = limits.down;
        end else if (cnt > 0) begin
            cnt_next = '0;
        end else begin
            cnt_next = cnt - count_t'(1);
        end
    end

endmodule

`default_nettype wire

/* rtl/core/focus_direction_filter_core.sv */
`default_nettype none
// An accepted input beat shifts into the histories; its result beat is then registered
// into the output register. Throughput: one beat per cycle unless m_tready stalls the
// output; the trend, spread and counter update form one registered stage before it.
// Reset (aresetn low, synchronous): histories and counters clear, registers take
// their defaults, and both channels hold no data.

module focus_direction_filter_core
    import fdf_pkg::*;
(
    input  wire               aclk,
    input  wire               aresetn,

    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire [IN_W-1:0]    s_tdata,   // focus_long[23:0], focus_short[47:24]
    input  wire               s_tuser,   // opcode

    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [OUT_W-1:0]  m_tdata,   // total_long[26:0], spread_long[55:27],
                                         // count_long[60:56], total_short[87:61],
                                         // spread_short[115:88], count_short[120:116]

    input  wire               psel,
    input  wire               penable,
    input  wire               pwrite,
    input  wire [ADDR_W-1:0]  paddr,
    input  wire [APB_W-1:0]   pwdata,
    output logic [APB_W-1:0]  prdata,
    output logic              pready
);

    logic signed [OFS_W-1:0] ofs_long_reg, ofs_short_reg;
    logic [UP_W-1:0]         up_long_reg, up_short_reg;
    count_t                  down_long_reg, down_short_reg;

    sample_t                 lh_reg [HIST_N];
    sample_t                 sh_reg [HIST_N];
    count_t                  cnt_long_reg, cnt_short_reg;
    count_t                  cnt_long_next, cnt_short_next;

    logic                    s1_valid_reg;
    logic                    s1_clear_reg;
    logic                    s1_adv;
    logic                    s_accept;
    logic                    cfg_write;
    reg_idx_t                cfg_idx;

    calc_t                   tl, sl, ts, ss, dl, ds;
    dir_limits_t             lim_long, lim_short;
    count_t                  cnt_long_out, cnt_short_out;

    logic                    m_valid_reg;
    logic [OUT_W-1:0]        m_data_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ofs_long_reg   <= '0;
            ofs_short_reg  <= '0;
            up_long_reg    <= UP_W'(3);
            up_short_reg   <= UP_W'(3);
            down_long_reg  <= -count_t'(3);
            down_short_reg <= -count_t'(3);
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_OFS_LONG:   ofs_long_reg   <= pwdata[OFS_W-1:0];
                REG_OFS_SHORT:  ofs_short_reg  <= pwdata[OFS_W-1:0];
                REG_UP_LONG:    up_long_reg    <= pwdata[UP_W-1:0];
                REG_UP_SHORT:   up_short_reg   <= pwdata[UP_W-1:0];
                REG_DOWN_LONG:  down_long_reg  <= pwdata[CNT_W-1:0];
                REG_DOWN_SHORT: down_short_reg <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_OFS_LONG:   prdata = APB_W'(ofs_long_reg);
            REG_OFS_SHORT:  prdata = APB_W'(ofs_short_reg);
            REG_UP_LONG:    prdata = {{(APB_W-UP_W){1'b0}}, up_long_reg};
            REG_UP_SHORT:   prdata = {{(APB_W-UP_W){1'b0}}, up_short_reg};
            REG_DOWN_LONG:  prdata = APB_W'(down_long_reg);
            REG_DOWN_SHORT: prdata = APB_W'(down_short_reg);
            default:        prdata = '0;
        endcase
    end

    assign s1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < HIST_N; i++) begin
                lh_reg[i] <= '0;
                sh_reg[i] <= '0;
            end
        end else if (s_accept) begin
            if (opcode_t'(s_tuser) == OP_CLEAR) begin
                for (int i = 0; i < HIST_N; i++) begin
                    lh_reg[i] <= '0;
                    sh_reg[i] <= '0;
                end
            end else begin
                for (int i = HIST_N - 1; i > 0; i--) begin
                    lh_reg[i] <= lh_reg[i-1];
                    sh_reg[i] <= sh_reg[i-1];
                end
                lh_reg[0] <= s_tdata[DATA_W-1:0];
                sh_reg[0] <= s_tdata[FIELD_W+DATA_W-1:FIELD_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s1_clear_reg <= 1'b0;
        end else if (s_tready) begin
            s1_valid_reg <= s_tvalid;
            s1_clear_reg <= (opcode_t'(s_tuser) == OP_CLEAR);
        end
    end

    always_comb begin
        tl = widen(lh_reg[0]) + widen(lh_reg[1]) + widen(lh_reg[2])
           - widen(lh_reg[4]) - widen(lh_reg[5]) - widen(lh_reg[6]);
        dl = absd(lh_reg[6], lh_reg[5]) + absd(lh_reg[5], lh_reg[4])
           + absd(lh_reg[4], lh_reg[3]) + absd(lh_reg[3], lh_reg[2])
           + absd(lh_reg[2], lh_reg[1]) + absd(lh_reg[1], lh_reg[0]);
        sl = dl + (dl >>> 1) + calc_t'(ofs_long_reg);

        ts = calc_t'(3) * widen(sh_reg[0]) - widen(sh_reg[2])
           - widen(sh_reg[4]) - widen(sh_reg[6]);
        ds = absd(sh_reg[0], sh_reg[2]) + absd(sh_reg[2], sh_reg[4])
           + absd(sh_reg[4], sh_reg[6]);
        ss = ds + (ds >>> 1) + calc_t'(ofs_short_reg);
    end

    assign lim_long  = '{up: up_long_reg,  down: down_long_reg};
    assign lim_short = '{up: up_short_reg, down: down_short_reg};

    fdf_dir_count u_count_long (
        .total    (tl),
        .spread   (sl),
        .cnt      (cnt_long_reg),
        .limits   (lim_long),
        .cnt_next (cnt_long_next)
    );

    fdf_dir_count u_count_short (
        .total    (ts),
        .spread   (ss),
        .cnt      (cnt_short_reg),
        .limits   (lim_short),
        .cnt_next (cnt_short_next)
    );

    assign cnt_long_out  = s1_clear_reg ? cnt_long_reg  : cnt_long_next;
    assign cnt_short_out = s1_clear_reg ? cnt_short_reg : cnt_short_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_long_reg  <= '0;
            cnt_short_reg <= '0;
        end else if (s1_valid_reg && s1_adv) begin
            cnt_long_reg  <= cnt_long_out;
            cnt_short_reg <= cnt_short_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_adv) begin
            m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg && s1_adv) begin
            m_data_reg <= {
                {(OUT_W - 2*TOT_W - SPL_W - SPS_W - 2*CNT_W){1'b0}},
                cnt_short_out,
                ss[SPS_W-1:0],
                ts[TOT_W-1:0],
                cnt_long_out,
                sl[SPL_W-1:0],
                tl[TOT_W-1:0]
            };
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

`default_nettype wire

/* tb/tb_focus_direction_filter_core.sv */
`default_nettype none

module tb_focus_direction_filter_core;
    timeunit 1ns;
    timeprecision 1ps;

    import fdf_pkg::*;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam logic [23:0] FOCUS_MAX = 24'hFFFFFF;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS = 235;

    class focus_trend_scoreboard;
        typedef struct {
            logic signed [26:0] total_long;
            logic signed [28:0] spread_long;
            logic signed [4:0]  count_long;
            logic signed [26:0] total_short;
            logic signed [27:0] spread_short;
            logic signed [4:0]  count_short;
        } trend_t;

        longint long_taps[7];
        longint short_taps[7];
        longint long_dir, short_dir;
        longint ofs_long, ofs_short, up_long, up_short, down_long, down_short;
        trend_t trend_q[$];
        int errors;

        function new();
            foreach (long_taps[i]) begin
                long_taps[i] = 0;
                short_taps[i] = 0;
            end
            long_dir = 0;
            short_dir = 0;
            ofs_long = 0;
            ofs_short = 0;
            up_long = 3;
            up_short = 3;
            down_long = -3;
            down_short = -3;
            errors = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (reg_idx_t'(idx))
                REG_OFS_LONG:   ofs_long = longint'($signed(val[20:0]));
                REG_OFS_SHORT:  ofs_short = longint'($signed(val[20:0]));
                REG_UP_LONG:    up_long = longint'(val[3:0]);
                REG_UP_SHORT:   up_short = longint'(val[3:0]);
                REG_DOWN_LONG:  down_long = longint'($signed(val[4:0]));
                REG_DOWN_SHORT: down_short = longint'($signed(val[4:0]));
                default: ;
            endcase
        endfunction

        function longint absdiff(longint a, longint b);
            return (a > b) ? a - b : b - a;
        endfunction

        function longint step_dir(longint cnt, longint total, longint spread,
                                  longint up, longint down);
            longint mag;
            mag = (total < 0) ? -total : total;
            if (!(mag > spread))
                return 0;
            if (total > 0)
                return (cnt >= up) ? up : cnt + 1;
            if (cnt <= down)
                return down;
            if (cnt > 0)
                return 0;
            return cnt - 1;
        endfunction

        function void note_input(opcode_t op, logic [23:0] fl, logic [23:0] fs);
            longint tl, sl, ts, ss, d;
            trend_t e;
            if (op == OP_CLEAR) begin
                foreach (long_taps[i]) begin
                    long_taps[i] = 0;
                    short_taps[i] = 0;
                end
            end else begin
                for (int i = 6; i > 0; i--) begin
                    long_taps[i] = long_taps[i-1];
                    short_taps[i] = short_taps[i-1];
                end
                long_taps[0] = longint'(fl);
                short_taps[0] = longint'(fs);
            end
            tl = long_taps[0] + long_taps[1] + long_taps[2]
               - long_taps[4] - long_taps[5] - long_taps[6];
            d = 0;
            for (int i = 0; i < 6; i++)
                d += absdiff(long_taps[i], long_taps[i+1]);
            sl = d + (d >>> 1) + ofs_long;
            ts = 3 * short_taps[0] - short_taps[2] - short_taps[4] - short_taps[6];
            d = absdiff(short_taps[0], short_taps[2]) + absdiff(short_taps[2], short_taps[4])
              + absdiff(short_taps[4], short_taps[6]);
            ss = d + (d >>> 1) + ofs_short;
            if (op != OP_CLEAR) begin
                long_dir = step_dir(long_dir, tl, sl, up_long, down_long);
                short_dir = step_dir(short_dir, ts, ss, up_short, down_short);
            end
            e.total_long = 27'(tl);
            e.spread_long = 29'(sl);
            e.count_long = 5'(long_dir);
            e.total_short = 27'(ts);
            e.spread_short = 28'(ss);
            e.count_short = 5'(short_dir);
            trend_q.push_back(e);
        endfunction

        function void cmp(string name, longint exp_v, longint act_v);
            if (exp_v != act_v) begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_W-1:0] d);
            trend_t e;
            if (trend_q.size() == 0) begin
                $error("result beat arrived with no expectation waiting");
                errors++;
                return;
            end
            e = trend_q.pop_front();
            cmp("total_long", e.total_long, $signed(d[26:0]));
            cmp("spread_long", e.spread_long, $signed(d[55:27]));
            cmp("count_long", e.count_long, $signed(d[60:56]));
            cmp("total_short", e.total_short, $signed(d[87:61]));
            cmp("spread_short", e.spread_short, $signed(d[115:88]));
            cmp("count_short", e.count_short, $signed(d[120:116]));
        endfunction

        function int pending();
            return trend_q.size();
        endfunction

        function void final_check();
            if (trend_q.size() != 0) begin
                $error("%0d expected result beats never arrived", trend_q.size());
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;  // focus_long, focus_short
    logic              s_tuser = 1'b0;  // opcode
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;  // total_long, spread_long, count_long, total_short,
                                 // spread_short, count_short
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [APB_W-1:0]  pwdata = '0;
    logic [APB_W-1:0]  prdata;
    logic              pready;

    focus_trend_scoreboard sb = new();
    bit idle_on = 1'b1;
    bit hold_req = 1'b0;
    longint ramp_long_val = 0, ramp_long_step = 0;
    longint ramp_short_val = 0, ramp_short_step = 0;
    int ramp_long_len = 0, ramp_short_len = 0;

    focus_direction_filter_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // The receiver idles at random, and on request holds off for a long stretch
    // so that the block fills up and stalls its input.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else if (hold_left > 0) begin
                hold_left--;
            end else begin
                m_tready <= !(idle_on && $urandom_range(99) < 22);
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                    || (psel && penable && pready))
                stall = 0;
            else
                stall++;
        end
        $display("Regression FAIL");
        $finish;
    end

    task automatic send_beat(input opcode_t op, input logic [23:0] fl, input logic [23:0] fs);
        if (idle_on && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {fs, fl};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, fl, fs);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] rd;
        bit ok;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        sb.set_reg(idx, val);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        rd = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
        case (reg_idx_t'(idx))
            REG_OFS_LONG:   ok = rd[20:0] == 21'(sb.ofs_long);
            REG_OFS_SHORT:  ok = rd[20:0] == 21'(sb.ofs_short);
            REG_UP_LONG:    ok = rd[3:0] == 4'(sb.up_long);
            REG_UP_SHORT:   ok = rd[3:0] == 4'(sb.up_short);
            REG_DOWN_LONG:  ok = rd[4:0] == 5'(sb.down_long);
            REG_DOWN_SHORT: ok = rd[4:0] == 5'(sb.down_short);
            default:        ok = 1'b1;
        endcase
        if (!ok) begin
            $error("register %0d readback: expected 0x%0h, got 0x%0h", idx, val, rd);
            sb.errors++;
        end
    endtask

    function automatic logic [23:0] ramp_next(ref longint val, ref longint step, ref int len);
        if (len == 0) begin
            len = $urandom_range(4, 14);
            step = longint'($urandom_range(0, 1 << $urandom_range(4, 21)));
            if ($urandom_range(1))
                step = -step;
            if ($urandom_range(7) == 0)
                val = $urandom_range(1) ? longint'(FOCUS_MAX) : 0;
        end
        val += step;
        if (val < 0)
            val = 0;
        if (val > longint'(FOCUS_MAX))
            val = longint'(FOCUS_MAX);
        len--;
        return 24'(val);
    endfunction

    function automatic logic [23:0] noise_focus();
        case ($urandom_range(7))
            0:       return '0;
            1:       return FOCUS_MAX;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [31:0] rand_offset();
        int v;
        v = $urandom_range(0, (1 << $urandom_range(0, 20)) - 1);
        return $urandom_range(1) ? 32'(-v - 1) : 32'(v);
    endfunction

    task automatic send_random();
        int pick;
        logic [23:0] fl, fs;
        pick = $urandom_range(99);
        if (pick < 3) begin
            send_beat(OP_CLEAR, 24'($urandom()), 24'($urandom()));
        end else if (pick < 18) begin
            fl = noise_focus();
            fs = noise_focus();
            send_beat(OP_SAMPLE, fl, fs);
        end else begin
            fl = ramp_next(ramp_long_val, ramp_long_step, ramp_long_len);
            fs = ramp_next(ramp_short_val, ramp_short_step, ramp_short_len);
            send_beat(OP_SAMPLE, fl, fs);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Extremes and alternating bit patterns, then a clear with nonzero data.
        send_beat(OP_SAMPLE, '0, '0);
        send_beat(OP_SAMPLE, FOCUS_MAX, FOCUS_MAX);
        send_beat(OP_SAMPLE, FOCUS_MAX, '0);
        send_beat(OP_SAMPLE, '0, FOCUS_MAX);
        send_beat(OP_SAMPLE, 24'hAAAAAA, 24'h555555);
        send_beat(OP_SAMPLE, 24'h555555, 24'hAAAAAA);
        send_beat(OP_CLEAR, FOCUS_MAX, FOCUS_MAX);
        // A rising ramp saturates both counters at the upper limit, a falling one
        // snaps them to zero and walks them down to the lower limit.
        for (int k = 1; k <= 8; k++)
            send_beat(OP_SAMPLE, 24'(k * 24'h1F0000), 24'(k * 24'h1F0000));
        for (int k = 8; k >= 1; k--)
            send_beat(OP_SAMPLE, 24'(k * 24'h1F0000), 24'(k * 24'h1F0000));
        // A clear leaves the counters where they are.
        send_beat(OP_CLEAR, '0, '0);
        send_beat(OP_SAMPLE, FOCUS_MAX, FOCUS_MAX);

        for (int ph = 0; ph < 8; ph++) begin
            drain();
            case (ph)
                0: ;
                1: begin
                    cfg_write(REG_OFS_LONG, 32'd0);
                    cfg_write(REG_OFS_SHORT, 32'd0);
                    cfg_write(REG_UP_LONG, 32'd14);
                    cfg_write(REG_UP_SHORT, 32'd14);
                    cfg_write(REG_DOWN_LONG, 32'(-14));
                    cfg_write(REG_DOWN_SHORT, 32'(-14));
                end
                2: begin
                    cfg_write(REG_OFS_LONG, 32'd1048575);
                    cfg_write(REG_OFS_SHORT, 32'(-1048576));
                    cfg_write(REG_UP_LONG, 32'd1);
                    cfg_write(REG_UP_SHORT, 32'd1);
                    cfg_write(REG_DOWN_LONG, 32'(-1));
                    cfg_write(REG_DOWN_SHORT, 32'(-1));
                    cfg_write(REG_SPARE_A, $urandom());
                    cfg_write(REG_SPARE_B, $urandom());
                end
                3: begin
                    // Limits outside their stated range, with junk in the upper bits.
                    cfg_write(REG_OFS_LONG, 32'(-1048576));
                    cfg_write(REG_OFS_SHORT, 32'd1048575);
                    cfg_write(REG_UP_LONG, ($urandom() & ~32'hF) | 32'hF);
                    cfg_write(REG_UP_SHORT, $urandom() & ~32'hF);
                    cfg_write(REG_DOWN_LONG, ($urandom() & ~32'h1F) | 32'h10);
                    cfg_write(REG_DOWN_SHORT, ($urandom() & ~32'h1F) | 32'h0F);
                end
                default: begin
                    cfg_write(REG_OFS_LONG, rand_offset());
                    cfg_write(REG_OFS_SHORT, rand_offset());
                    cfg_write(REG_UP_LONG, 32'($urandom_range(1, 14)));
                    cfg_write(REG_UP_SHORT, 32'($urandom_range(1, 14)));
                    cfg_write(REG_DOWN_LONG, 32'(-$urandom_range(1, 14)));
                    cfg_write(REG_DOWN_SHORT, 32'(-$urandom_range(1, 14)));
                end
            endcase
            idle_on = (ph != 1);
            if (ph == 1)
                hold_req = 1'b1;
            repeat (PHASE_ITEMS) send_random();
        end

        idle_on = 1'b1;
        drain();
        repeat (10) @(posedge aclk);
        sb.final_check();
        if (sb.errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
rtl/core/fdf_pkg.sv
rtl/core/fdf_dir_count.sv
rtl/core/focus_direction_filter_core.sv
tb/tb_focus_direction_filter_core.sv
